### rtl/core/pres_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pres_pkg
// shared constants and types for the pagerank edge scatter engine
// ----------------------------------------------------------------------------
package pres_pkg;
   localparam int NODES_DEF       = 1024;
   localparam int DEGREE_BITS_DEF = 24;
   localparam int RANK_W          = 32;
   localparam int DAMP_W          = 16;
   localparam int CNT_W           = 11;
   localparam int NODE_W          = 10;
   localparam int DVAL_W          = 24;
   localparam int CMD_W           = 3;

   localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DEGREE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_EDGE   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FINISH = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   localparam logic [1:0] REG_NODE_COUNT   = 2'd0;
   localparam logic [1:0] REG_DAMPING      = 2'd1;
   localparam logic [1:0] REG_BASE_TERM    = 2'd2;
   localparam logic [1:0] REG_INITIAL_RANK = 2'd3;

   localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 11'd1024;
   localparam logic [DAMP_W-1:0] DAMPING_RST    = 16'd55706;
   localparam logic [RANK_W-1:0] RANK_MAX       = 32'hFFFF_FFFF;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;
endpackage

### rtl/core/pres_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pres_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module pres_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end
   assign rdata = rdata_ff;
endmodule

### rtl/core/pres_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pres_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pres_div #(
   parameter int DBITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [pres_pkg::RANK_W-1:0] dividend,
   input  logic [DBITS-1:0]          divisor,
   output pres_pkg::div_ctl_type     ctl,
   output logic [pres_pkg::RANK_W-1:0] quotient
);
   localparam int RW = pres_pkg::RANK_W;
   localparam int SW = $clog2(RW + 1);

   logic [RW-1:0] quo_ff, quo_in;
   logic [DBITS-1:0] rem_ff, rem_in;
   logic [DBITS-1:0] dsr_ff, dsr_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [DBITS:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[RW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = SW'(RW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DBITS'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[RW-2:0], 1'b1};
         end else begin
            rem_in = trial[DBITS-1:0];
            quo_in = {quo_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == SW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign quotient  = quo_ff;
endmodule

### rtl/core/pagerank_edge_scatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagerank_edge_scatter
// pagerank power iteration engine with serial divider and per-node stores
// ----------------------------------------------------------------------------
// edge: reads degree and rank of node_a, runs the 32-step divider, adds the quotient into node_b
// degree writes the degree store; bad index or zero degree sets error_flag; unused cmd just answers
// read returns the stored rank of node_a; init and finish sweep the n nodes in use
// one request at a time; result held in an output register until taken
// reset is synchronous; ranks and accumulators are undefined until init
// ----------------------------------------------------------------------------
module pagerank_edge_scatter #(
   parameter int NODES       = pres_pkg::NODES_DEF,
   parameter int DEGREE_BITS = pres_pkg::DEGREE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[2:0], node_a[12:3], node_b[22:13], degree_value[46:23]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rank_value[31:0], error_flag[32], saturated_flag[33]
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int RW = pres_pkg::RANK_W;
   localparam int AW = $clog2(NODES);
   localparam int CW = pres_pkg::CNT_W;
   localparam int NW = pres_pkg::NODE_W;
   localparam int UW = (AW + 1 > CW) ? AW + 1 : CW;
   localparam int MW = pres_pkg::DAMP_W + RW;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RD1   = 4'd1;
   localparam logic [3:0] ST_RD2   = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_ACC1  = 4'd4;
   localparam logic [3:0] ST_ACC2  = 4'd5;
   localparam logic [3:0] ST_SWEEP = 4'd6;
   localparam logic [3:0] ST_FRD   = 4'd7;
   localparam logic [3:0] ST_FMUL  = 4'd8;
   localparam logic [3:0] ST_FWR   = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] ncount_ff, ncount_in;
   logic [pres_pkg::DAMP_W-1:0] damp_ff, damp_in;
   logic [RW-1:0] base_ff, base_in, init_ff, init_in;
   logic [pres_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [NW-1:0] na_ff, na_in, nb_ff, nb_in;
   logic [DEGREE_BITS-1:0] dval_ff, dval_in;
   logic [UW-1:0] idx_ff, idx_in;
   logic [RW-1:0] rank_ff, rank_in;
   logic err_ff, err_in, sat_ff, sat_in, ovalid_ff, ovalid_in;
   logic [MW-1:0] prod_ff, prod_in;

   logic [UW-1:0] count;
   logic a_ok, b_ok, bad;
   logic deg_we, prev_we, acc_we;
   logic [AW-1:0] deg_addr, prev_addr, acc_addr;
   logic [DEGREE_BITS-1:0] deg_wdata, deg_rdata;
   logic [RW-1:0] prev_wdata, prev_rdata, acc_wdata, acc_rdata;
   logic div_start;
   pres_pkg::div_ctl_type div_ctl;
   logic [RW-1:0] quotient;
   logic [RW:0] sum;
   logic [RW:0] fsum;
   logic [pres_pkg::DVAL_W-1:0] req_dval;

   assign req_dval = req_tdata[46:23];
   assign count = (UW'(ncount_ff) > UW'(NODES)) ? UW'(NODES) : UW'(ncount_ff);
   assign a_ok = {{(UW-NW){1'b0}}, na_ff} < count;
   assign b_ok = {{(UW-NW){1'b0}}, nb_ff} < count;
   assign bad  = (cmd_ff == pres_pkg::CMD_EDGE) ? !(a_ok && b_ok) : !a_ok;

   pres_ram #(.WIDTH(DEGREE_BITS), .DEPTH(NODES)) u_deg (
      .clock(clock), .we(deg_we), .addr(deg_addr), .wdata(deg_wdata), .rdata(deg_rdata));
   pres_ram #(.WIDTH(RW), .DEPTH(NODES)) u_prev (
      .clock(clock), .we(prev_we), .addr(prev_addr), .wdata(prev_wdata), .rdata(prev_rdata));
   pres_ram #(.WIDTH(RW), .DEPTH(NODES)) u_acc (
      .clock(clock), .we(acc_we), .addr(acc_addr), .wdata(acc_wdata), .rdata(acc_rdata));

   pres_div #(.DBITS(DEGREE_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(prev_rdata),
      .divisor(deg_rdata), .ctl(div_ctl), .quotient(quotient));

   assign sum  = {1'b0, acc_rdata} + {1'b0, quotient};
   assign fsum = {1'b0, base_ff} + {1'b0, prod_ff[MW-1:pres_pkg::DAMP_W]};

   always_comb begin
      state_in = state_ff;
      ncount_in = ncount_ff; damp_in = damp_ff; base_in = base_ff; init_in = init_ff;
      cmd_in = cmd_ff; na_in = na_ff; nb_in = nb_ff; dval_in = dval_ff;
      idx_in = idx_ff; rank_in = rank_ff; err_in = err_ff; sat_in = sat_ff;
      ovalid_in = ovalid_ff; prod_in = prod_ff;
      deg_we = 1'b0; prev_we = 1'b0; acc_we = 1'b0;
      deg_addr = AW'(na_ff); prev_addr = AW'(na_ff); acc_addr = AW'(nb_ff);
      deg_wdata = dval_ff; prev_wdata = init_ff; acc_wdata = '0;
      div_start = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pres_pkg::REG_NODE_COUNT:   ncount_in = csr_data[CW-1:0];
            pres_pkg::REG_DAMPING:      damp_in = csr_data[pres_pkg::DAMP_W-1:0];
            pres_pkg::REG_BASE_TERM:    base_in = csr_data;
            pres_pkg::REG_INITIAL_RANK: init_in = csr_data;
            default: ;
         endcase
      end
      if (rsp_tvalid && rsp_tready) begin
         ovalid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in = req_tdata[2:0];
               na_in = req_tdata[12:3];
               nb_in = req_tdata[22:13];
               dval_in = DEGREE_BITS'(req_dval);
               rank_in = '0; err_in = 1'b0; sat_in = 1'b0;
               idx_in = '0;
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            case (cmd_ff)
               pres_pkg::CMD_INIT, pres_pkg::CMD_FINISH: state_in = ST_SWEEP;
               pres_pkg::CMD_DEGREE: begin
                  if (bad) err_in = 1'b1;
                  else deg_we = 1'b1;
                  state_in = ST_OUT;
               end
               pres_pkg::CMD_EDGE, pres_pkg::CMD_READ: begin
                  if (bad) begin
                     err_in = 1'b1;
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_RD2;
                  end
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_RD2: begin
            if (cmd_ff == pres_pkg::CMD_READ) begin
               rank_in = prev_rdata;
               state_in = ST_OUT;
            end else if (deg_rdata == '0) begin
               err_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_ctl.busy) state_in = ST_ACC1;
         end
         ST_ACC1: state_in = ST_ACC2;
         ST_ACC2: begin
            acc_we = 1'b1;
            if (sum[RW]) begin
               acc_wdata = pres_pkg::RANK_MAX;
               sat_in = 1'b1;
            end else begin
               acc_wdata = sum[RW-1:0];
            end
            state_in = ST_OUT;
         end
         ST_SWEEP: begin
            if (idx_ff >= count) begin
               state_in = ST_OUT;
            end else if (cmd_ff == pres_pkg::CMD_INIT) begin
               prev_addr = idx_ff[AW-1:0]; acc_addr = idx_ff[AW-1:0];
               prev_we = 1'b1; acc_we = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               acc_addr = idx_ff[AW-1:0];
               state_in = ST_FRD;
            end
         end
         ST_FRD: begin
            acc_addr = idx_ff[AW-1:0];
            state_in = ST_FMUL;
         end
         ST_FMUL: begin
            prod_in = damp_ff * acc_rdata;
            state_in = ST_FWR;
         end
         ST_FWR: begin
            prev_addr = idx_ff[AW-1:0]; acc_addr = idx_ff[AW-1:0];
            prev_we = 1'b1; acc_we = 1'b1;
            if (fsum[RW]) begin
               prev_wdata = pres_pkg::RANK_MAX;
               sat_in = 1'b1;
            end else begin
               prev_wdata = fsum[RW-1:0];
            end
            idx_in = idx_ff + 1'b1;
            state_in = ST_SWEEP;
         end
         ST_OUT: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic [RW-1:0] orank_ff, orank_in;
   logic oerr_ff, oerr_in, osat_ff, osat_in;
   always_comb begin
      orank_in = orank_ff; oerr_in = oerr_ff; osat_in = osat_ff;
      if (state_ff == ST_OUT && (!ovalid_ff || rsp_tready)) begin
         orank_in = rank_ff; oerr_in = err_ff; osat_in = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
         ncount_ff <= pres_pkg::NODE_COUNT_RST;
         damp_ff   <= pres_pkg::DAMPING_RST;
         base_ff   <= '0;
         init_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         ncount_ff <= ncount_in;
         damp_ff   <= damp_in;
         base_ff   <= base_in;
         init_ff   <= init_in;
      end
      cmd_ff <= cmd_in; na_ff <= na_in; nb_ff <= nb_in; dval_ff <= dval_in;
      idx_ff <= idx_in; rank_ff <= rank_in; err_ff <= err_in; sat_ff <= sat_in;
      prod_ff <= prod_in;
      orank_ff <= orank_in; oerr_ff <= oerr_in; osat_ff <= osat_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {6'd0, osat_ff, oerr_ff, orank_ff};

`ifndef SYNTHESIS
   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> state_ff == ST_RD2)
      else $error("divider started outside edge path");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_ctl.busy)
      else $error("divider busy while idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
`endif
endmodule
